FILE: rtl/core/csv_kw_pkg.sv
package csv_kw_pkg;

    // Widths of the row counter and of the result's row number.
    localparam int ROW_BITS     = 32;
    localparam int ROW_OUT_BITS = 32;

    // Keyword table: sixteen slots, up to fifteen cleaned characters each.
    localparam int NUM_KEYWORDS = 5;
    localparam int KW_SLOTS     = 16;
    localparam int KW_MAXLEN    = 15;
    localparam int KW_POS_BITS  = 4;
    localparam int NUM_KW       = (NUM_KEYWORDS > KW_SLOTS) ? KW_SLOTS : NUM_KEYWORDS;

    // Byte codes with a meaning of their own.
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_VTAB    = 8'd11;
    localparam logic [7:0] CH_FFEED   = 8'd12;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DQUOTE  = 8'd34;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CASE_DELTA = 8'd32;

    // Keyword strings, right-justified as string literals are; unused slots are empty.
    localparam logic [8*KW_MAXLEN-1:0] KW_STR [KW_SLOTS] = '{
        0: "*deleted",
        1: "*notapplicable",
        2: "*unspecified",
        3: "*unknown",
        4: "na",
        default: '0
    };

    localparam logic [KW_POS_BITS-1:0] KW_LEN [KW_SLOTS] = '{
        0: 4'd8,
        1: 4'd14,
        2: 4'd12,
        3: 4'd8,
        4: 4'd2,
        default: 4'd0
    };

    // Control word from the byte decoder to the keyword matcher.
    typedef struct packed {
        logic       fire;
        logic       take;
        logic       close;
        logic [7:0] ch;
    } kw_ctrl_t;

    // Character at position pos of keyword slot k, or zero past its end.
    function automatic logic [7:0] kw_char(input int k, input logic [KW_POS_BITS-1:0] pos);
        logic [7:0] result;
        int         shift;
        result = 8'd0;
        shift  = 0;
        if (pos < KW_LEN[k])
        begin
            shift  = 8 * (int'(KW_LEN[k]) - 1 - int'(pos));
            result = KW_STR[k][shift +: 8];
        end
        return result;
    endfunction

endpackage

FILE: rtl/core/csv_kw_if.sv
// Input channel: one text byte per word.
interface csv_kw_in_if;
    import csv_kw_pkg::*;

    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_text;

    modport source (output valid, output text_byte, output end_of_text, input ready);
    modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Output channel: one line decision per word.
interface csv_kw_out_if;
    import csv_kw_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    keep_line;
    logic [ROW_OUT_BITS-1:0] row_number;
    logic                    is_header;

    modport source (output valid, output keep_line, output row_number, output is_header,
                    input ready);
    modport sink   (input valid, input keep_line, input row_number, input is_header,
                    output ready);
endinterface

FILE: rtl/core/csv_kw_match.sv
module csv_kw_match
    import csv_kw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  kw_ctrl_t ctrl,
    output logic     field_hit
);

    logic [KW_POS_BITS-1:0] pos_reg   [NUM_KW];
    logic [KW_POS_BITS-1:0] pos_next  [NUM_KW];
    logic [KW_POS_BITS-1:0] pos_taken [NUM_KW];
    logic [NUM_KW-1:0]      still_reg;
    logic [NUM_KW-1:0]      still_next;
    logic [NUM_KW-1:0]      still_taken;
    logic [NUM_KW-1:0]      lane_hit;
    logic                   has_chars_reg;
    logic                   has_chars_next;
    logic                   has_chars_taken;

    // One lane per keyword: advance on a matching character, drop out otherwise.
    for (genvar k = 0; k < NUM_KW; k++)
    begin : g_lane
        always_comb
        begin
            pos_taken[k]   = pos_reg[k];
            still_taken[k] = still_reg[k];
            if (ctrl.take && still_reg[k])
            begin
                if (pos_reg[k] < KW_LEN[k] && kw_char(k, pos_reg[k]) == ctrl.ch)
                begin
                    pos_taken[k] = pos_reg[k] + 1'b1;
                end
                else
                begin
                    still_taken[k] = 1'b0;
                end
            end
            lane_hit[k] = still_taken[k] && (KW_LEN[k] != '0) && (pos_taken[k] == KW_LEN[k]);
            pos_next[k] = ctrl.close ? '0 : pos_taken[k];
        end
    end

    // A field hits when it holds characters and some lane matched to the end.
    assign has_chars_taken = has_chars_reg | ctrl.take;
    assign field_hit       = has_chars_taken && (|lane_hit);
    assign still_next      = ctrl.close ? '1 : still_taken;
    assign has_chars_next  = ctrl.close ? 1'b0 : has_chars_taken;

    // Field state advances only on an accepted word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_KW; k++)
            begin
                pos_reg[k] <= '0;
            end
            still_reg     <= '1;
            has_chars_reg <= 1'b0;
        end
        else if (ctrl.fire)
        begin
            for (int k = 0; k < NUM_KW; k++)
            begin
                pos_reg[k] <= pos_next[k];
            end
            still_reg     <= still_next;
            has_chars_reg <= has_chars_next;
        end
    end

endmodule

FILE: rtl/core/csv_keyword_line_filter_unit.sv
// Channel   Modport  Word
// text_in   sink     text_byte[7:0], end_of_text
// line_out  source   keep_line, row_number[31:0], is_header
//
// One byte is taken every cycle while text_in.ready is high; a line decision is
// valid in the cycle after the line's newline or the last byte of the text.
// The keyword lanes and the line state update in the cycle a byte is taken.
// A byte is taken while the result register is empty or being emptied.
// Reset clears the row counter, the field and line state and the result valid.
module csv_keyword_line_filter_unit
    import csv_kw_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    csv_kw_in_if.sink         text_in,
    csv_kw_out_if.source      line_out
);

    kw_ctrl_t              ctrl;
    logic                  field_hit;
    logic                  fire;
    logic                  is_newline;
    logic                  is_comma;
    logic                  is_dropped;
    logic                  emit;
    logic                  line_unwanted;
    logic [7:0]            lower_ch;
    logic [ROW_BITS-1:0]   row_counter_reg;
    logic [ROW_BITS-1:0]   row_counter_next;
    logic                  line_unwanted_reg;
    logic                  line_unwanted_next;
    logic                  out_valid_reg;
    logic                  keep_reg;
    logic [ROW_OUT_BITS-1:0] row_reg;
    logic                  header_reg;

    assign text_in.ready = !out_valid_reg || line_out.ready;
    assign fire          = text_in.valid && text_in.ready;

    // Byte decoding.
    always_comb
    begin
        is_newline = (text_in.text_byte == CH_NEWLINE);
        is_comma   = (text_in.text_byte == CH_COMMA);
        is_dropped = (text_in.text_byte == CH_TAB)   || (text_in.text_byte == CH_VTAB) ||
                     (text_in.text_byte == CH_FFEED) || (text_in.text_byte == CH_CR)   ||
                     (text_in.text_byte == CH_SPACE) || (text_in.text_byte == CH_DQUOTE);
        lower_ch   = text_in.text_byte;
        if (text_in.text_byte >= CH_UPPER_A && text_in.text_byte <= CH_UPPER_Z)
        begin
            lower_ch = text_in.text_byte + CASE_DELTA;
        end
        ctrl.fire  = fire;
        ctrl.take  = !is_newline && !is_comma && !is_dropped;
        ctrl.close = is_newline || is_comma || text_in.end_of_text;
        ctrl.ch    = lower_ch;
    end

    csv_kw_match u_match (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .field_hit (field_hit)
    );

    // Line state and the saturating row counter.
    always_comb
    begin
        emit          = is_newline || text_in.end_of_text;
        line_unwanted = line_unwanted_reg || (ctrl.close && field_hit);
        row_counter_next = row_counter_reg;
        if (row_counter_reg != '1)
        begin
            row_counter_next = row_counter_reg + 1'b1;
        end
        line_unwanted_next = emit ? 1'b0 : line_unwanted;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_counter_reg   <= '0;
            line_unwanted_reg <= 1'b0;
        end
        else if (fire)
        begin
            line_unwanted_reg <= line_unwanted_next;
            if (emit)
            begin
                row_counter_reg <= row_counter_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire && emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (line_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && emit)
        begin
            header_reg <= (row_counter_next == ROW_BITS'(1));
            keep_reg   <= (row_counter_next == ROW_BITS'(1)) || !line_unwanted;
            row_reg    <= ROW_OUT_BITS'(row_counter_next);
        end
    end

    assign line_out.valid      = out_valid_reg;
    assign line_out.keep_line  = keep_reg;
    assign line_out.row_number = row_reg;
    assign line_out.is_header  = header_reg;

`ifndef SYNTH
    // A taken newline always leaves a result waiting in the next cycle.
    a_newline_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_newline) |=> out_valid_reg)
        else $error("newline taken without a result");

    // The header line is never dropped.
    a_header_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && header_reg) |-> keep_reg)
        else $error("header line marked for removal");

    // Row numbers start at one.
    a_row_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (row_reg != '0))
        else $error("result with row number zero");

    // A byte that neither ends a line nor finds the result busy leaves no result.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !emit && line_out.ready) |=> !out_valid_reg)
        else $error("result without a line end");
`endif

endmodule

FILE: tb/sv/csv_kw_line_checker.sv
// Watches both channels of the line filter, predicts every line decision from
// the accepted text words and compares each accepted result word against it.
module csv_kw_line_checker
    import csv_kw_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    csv_kw_in_if   text_in,
    csv_kw_out_if  line_out,
    output int     failures,
    output int     decisions_due
);

    localparam int KEYWORD_COUNT = 5;

    typedef struct packed {
        logic                    keep_line;
        logic [ROW_OUT_BITS-1:0] row_number;
        logic                    is_header;
    } line_decision_t;

    // Keywords as they look once a field has been cleaned.
    string keyword_text [KEYWORD_COUNT] =
        '{"*deleted", "*notapplicable", "*unspecified", "*unknown", "na"};

    // Predicted state of the block.
    logic [ROW_BITS-1:0]    lines_done;
    logic [KW_POS_BITS-1:0] matched_len [KEYWORD_COUNT];
    logic                   still_prefix [KEYWORD_COUNT];
    logic                   field_nonempty;
    logic                   line_flagged;

    line_decision_t expected_lines [$];
    int             mismatch_tally = 0;

    // Start a new field: every keyword is again a candidate.
    function automatic void clear_field_state();
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            matched_len[k]  = '0;
            still_prefix[k] = 1'b1;
        end
        field_nonempty = 1'b0;
    endfunction

    // A finished field flags the line if it spelled out a whole keyword.
    function automatic void close_field_state();
        if (field_nonempty)
        begin
            for (int k = 0; k < KEYWORD_COUNT; k++)
            begin
                if (still_prefix[k] && int'(matched_len[k]) == keyword_text[k].len())
                    line_flagged = 1'b1;
            end
        end
        clear_field_state();
    endfunction

    // Close the line and build its decision; the row count saturates.
    function automatic line_decision_t close_line_state();
        line_decision_t decision;
        close_field_state();
        if (lines_done != {ROW_BITS{1'b1}})
            lines_done = lines_done + 1'b1;
        decision.is_header  = (lines_done == 1);
        decision.keep_line  = decision.is_header || !line_flagged;
        decision.row_number = lines_done[ROW_OUT_BITS-1:0];
        line_flagged = 1'b0;
        return decision;
    endfunction

    // Advance every keyword lane that still matches by one lowercased character.
    function automatic void add_field_char(input logic [7:0] raw);
        logic [7:0] c;
        c = raw;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
            c = c + CASE_DELTA;
        field_nonempty = 1'b1;
        for (int k = 0; k < KEYWORD_COUNT; k++)
        begin
            if (still_prefix[k])
            begin
                if (int'(matched_len[k]) < keyword_text[k].len() &&
                    keyword_text[k][matched_len[k]] == c)
                    matched_len[k] = matched_len[k] + 1'b1;
                else
                    still_prefix[k] = 1'b0;
            end
        end
    endfunction

    function automatic bit is_dropped_byte(input logic [7:0] b);
        return b == CH_TAB || b == CH_VTAB || b == CH_FFEED || b == CH_CR ||
               b == CH_SPACE || b == CH_DQUOTE;
    endfunction

    // Result words are checked before the text word of the same edge is applied,
    // since a decision always belongs to an earlier byte.
    always @(posedge clk or negedge rst_n)
    begin : track_lines
        line_decision_t due;
        if (!rst_n)
        begin
            lines_done   = '0;
            line_flagged = 1'b0;
            clear_field_state();
            expected_lines.delete();
            decisions_due <= 0;
        end
        else
        begin
            if (line_out.valid && line_out.ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("unexpected line decision: row_number %0d", line_out.row_number);
                    mismatch_tally++;
                end
                else
                begin
                    due = expected_lines.pop_front();
                    if (line_out.keep_line !== due.keep_line)
                    begin
                        $error("keep_line mismatch: expected %0d, actual %0d",
                               due.keep_line, line_out.keep_line);
                        mismatch_tally++;
                    end
                    if (line_out.row_number !== due.row_number)
                    begin
                        $error("row_number mismatch: expected %0d, actual %0d",
                               due.row_number, line_out.row_number);
                        mismatch_tally++;
                    end
                    if (line_out.is_header !== due.is_header)
                    begin
                        $error("is_header mismatch: expected %0d, actual %0d",
                               due.is_header, line_out.is_header);
                        mismatch_tally++;
                    end
                end
            end

            // Any byte other than a newline opens the line, so a last byte
            // always closes one.
            if (text_in.valid && text_in.ready)
            begin
                if (text_in.text_byte == CH_NEWLINE)
                    expected_lines.insert(expected_lines.size(), close_line_state());
                else
                begin
                    if (text_in.text_byte == CH_COMMA)
                        close_field_state();
                    else if (!is_dropped_byte(text_in.text_byte))
                        add_field_char(text_in.text_byte);
                    if (text_in.end_of_text)
                        expected_lines.insert(expected_lines.size(), close_line_state());
                end
            end

            failures      <= mismatch_tally;
            decisions_due <= expected_lines.size();
        end
    end

endmodule

FILE: tb/sv/tb_csv_keyword_line_filter_unit.sv
// Drives CSV text into the line filter and gives the verdict; prediction and
// comparison live in the checker instance.
module tb_csv_keyword_line_filter_unit
    import csv_kw_pkg::*;
;

    localparam int TEXT_BYTES       = 1950;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int PHASE_BYTES      = 150;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   lines_pending;
    int   bytes_sent = 0;
    int   decisions_taken = 0;
    bit   steady_flow = 1'b0;

    logic [7:0] line_text [$];
    string      keyword_text [5] =
        '{"*deleted", "*notapplicable", "*unspecified", "*unknown", "na"};

    csv_kw_in_if  text_ch ();
    csv_kw_out_if line_ch ();

    csv_keyword_line_filter_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_ch),
        .line_out (line_ch)
    );

    csv_kw_line_checker line_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .text_in       (text_ch),
        .line_out      (line_ch),
        .failures      (fail_count),
        .decisions_due (lines_pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // Hard limit on the whole run.
    initial
    begin
        #20000000;
        $display("CHECK FAILED");
        $finish;
    end

    // Add one byte to the end of the line being built.
    function automatic void append_byte(input logic [7:0] b);
        line_text.insert(line_text.size(), b);
    endfunction

    // Offer one text word after a random gap, or none in steady flow, and wait until it is taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 16);
        if (gap > 0)
        begin
            text_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        text_ch.valid       <= 1'b1;
        text_ch.text_byte   <= b;
        text_ch.end_of_text <= last;
        @(posedge clk);
        while (!text_ch.ready)
            @(posedge clk);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Send the collected line; optionally its last byte ends the text.
    task automatic send_line_text(input bit last_ends_text);
        for (int i = 0; i < line_text.size(); i++)
            send_byte(line_text[i], last_ends_text && i == line_text.size() - 1);
        line_text.delete();
    endtask

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_byte(s[i]);
    endfunction

    function automatic logic [7:0] filler_byte();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0:       b = CH_SPACE;
            1:       b = CH_TAB;
            2:       b = CH_DQUOTE;
            3:       b = CH_CR;
            4:       b = CH_VTAB;
            default: b = CH_FFEED;
        endcase
        return b;
    endfunction

    // One field: often a keyword in disguise, else a near miss, empty, plain text or raw bytes.
    function automatic void put_field();
        int         kind;
        int         n;
        string      w;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        w    = keyword_text[$urandom_range(0, 4)];
        if (kind <= 3)
        begin
            for (int i = 0; i < w.len(); i++)
            begin
                if ($urandom_range(0, 4) == 0)
                    append_byte(filler_byte());
                c = w[i];
                if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1)
                    c = c - CASE_DELTA;
                append_byte(c);
            end
            if ($urandom_range(0, 3) == 0)
                append_byte(filler_byte());
        end
        else if (kind == 4)
        begin
            // Near miss: one character short or one too many.
            n = ($urandom_range(0, 1) == 1) ? w.len() - 1 : w.len();
            for (int i = 0; i < n; i++)
                append_byte(w[i]);
            if (n == w.len())
                append_byte(8'($urandom_range(97, 122)));
        end
        else if (kind == 5)
        begin
            n = $urandom_range(0, 2);
            for (int i = 0; i < n; i++)
                append_byte(filler_byte());
        end
        else if (kind <= 8)
        begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(33, 126));
                if (c == CH_COMMA)
                    c = c + 1'b1;
                append_byte(c);
            end
        end
        else
        begin
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
            begin
                c = 8'($urandom_range(0, 255));
                if (c == CH_NEWLINE || c == CH_COMMA)
                    c = c ^ 8'h80;
                append_byte(c);
            end
        end
    endfunction

    // Well-formed line of random fields with a random ending.
    task automatic send_random_line();
        int nf;
        int ending;
        nf = $urandom_range(1, 5);
        for (int f = 0; f < nf; f++)
        begin
            if (f > 0)
                append_byte(CH_COMMA);
            put_field();
        end
        ending = $urandom_range(0, 19);
        if (ending == 1 && line_text.size() > 0)
            send_line_text(1'b1);
        else
        begin
            append_byte(CH_NEWLINE);
            send_line_text(ending == 0);
        end
    endtask

    // Raw bytes of any value, now and then marking the end of the text.
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 20);
        for (int i = 0; i < n; i++)
            send_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    endtask

    // Receiver: random stall per result word, with two long hold-offs.
    initial
    begin : take_decisions
        int stall;
        line_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = steady_flow ? 0 : $urandom_range(0, 16);
            if (decisions_taken == 5 || decisions_taken == 40)
                stall = LONG_HOLD_CYCLES;
            if (stall > 0)
            begin
                line_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            line_ch.ready <= 1'b1;
            @(posedge clk);
            while (!line_ch.valid)
                @(posedge clk);
            decisions_taken++;
            @(negedge clk);
        end
    end

    // Stimulus and verdict.
    initial
    begin : make_text
        int next_phase;
        text_ch.valid       = 1'b0;
        text_ch.text_byte   = '0;
        text_ch.end_of_text = 1'b0;
        rst_n               = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Header that looks like a keyword, then an empty line.
        put_text("NA\n");
        send_line_text(1'b0);
        put_text("\n");
        send_line_text(1'b0);
        // Quoted keyword with spaces, then a field of extreme and dropped bytes.
        put_text("\"n A\",");
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(CH_TAB);
        append_byte(CH_VTAB);
        append_byte(CH_FFEED);
        append_byte(CH_CR);
        append_byte(CH_NEWLINE);
        send_line_text(1'b0);
        // Empty fields and a keyword closed by the end of the text mid-line.
        put_text(",,*unKnown");
        send_line_text(1'b1);

        next_phase = 0;
        while (bytes_sent < TEXT_BYTES)
        begin
            if (bytes_sent >= next_phase)
            begin
                steady_flow = ($urandom_range(0, 3) == 0);
                next_phase  = next_phase + PHASE_BYTES;
            end
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_random_line();
        end
        steady_flow = 1'b0;
        text_ch.valid <= 1'b0;

        while (lines_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/csv_kw_pkg.sv
rtl/core/csv_kw_if.sv
rtl/core/csv_kw_match.sv
rtl/core/csv_keyword_line_filter_unit.sv
tb/sv/csv_kw_line_checker.sv
tb/sv/tb_csv_keyword_line_filter_unit.sv
